// ===== design/upd_pkg.sv =====
// Shared types, constants and character helpers for the URI percent decoder.
// Depends on nothing; all design files but the checker use it by scoped names.
package upd_pkg;

    localparam logic [7:0]  PCT             = 8'h25;   // '%'
    localparam logic [7:0]  HEX_CASE_MASK   = 8'hDF;   // folds lower-case letters to upper
    localparam logic [7:0]  HEX_LETTER_BASE = 8'd10;   // value of 'A'
    localparam logic [7:0]  CH_0            = 8'h30;
    localparam logic [7:0]  CH_9            = 8'h39;
    localparam logic [7:0]  CH_UA           = 8'h41;
    localparam logic [7:0]  CH_UF           = 8'h46;
    localparam logic [7:0]  CH_LA           = 8'h61;
    localparam logic [7:0]  CH_LF           = 8'h66;

    localparam logic [15:0] CNT_RESET       = 16'd1;      // terminator slot
    localparam logic [15:0] CNT_MAX         = 16'hFFFF;
    localparam logic [15:0] CAP_RESET       = 16'hFFFF;

    // Register indexes, taken from paddr[2].
    localparam logic        REG_COUNT_ONLY  = 1'b0;
    localparam logic        REG_CAPACITY    = 1'b1;

    localparam int          ENTRY_BYTES     = 3;

    // One classified input byte: up to three raw bytes released for output.
    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] data;
        logic [1:0]                  count;
        logic                        last;
    } t_entry;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
                 (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UA) begin
            v = ((c & HEX_CASE_MASK) - CH_UA) + HEX_LETTER_BASE;
        end else begin
            v = c - CH_0;
        end
        hex_val = v[3:0];
    endfunction

endpackage

// ===== design/uri_percent_decoder_core.sv =====
// Top level of the URI percent decoder; depends on upd_pkg, upd_front, upd_queue, upd_back.
// The first result of an accepted byte passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue has room; a byte releasing n > 1 decoded
// bytes holds the back end while it walks them, and an untaken result holds it until taken.
// Reset (i_rst_n low, synchronous) clears the escape state, queue, counters and output valid,
// and sets count_only to 0 and capacity to 65535.
module uri_percent_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input byte stream
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // Decoded result stream
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_out_last,
    output logic [15:0] o_total_length,
    output logic        o_overflow
);

    // The design splits into three parts. The front end classifies each input
    // byte against the held escape ('%' alone, or '%' and one hex digit) and
    // turns it into an entry of zero to three raw bytes. A broken escape
    // releases the literal '%' (and digit) plus the breaking byte; a breaking
    // '%' becomes a new escape. A string's last byte flushes anything held.
    //
    // A two-entry queue sits between the front and back ends, so an input
    // transaction is taken whenever the queue has room, independent of the
    // output side. The back end walks each entry one byte per cycle while the
    // output register is free or taken, keeps the written count (starting at one
    // for the terminator, saturating at 65535) and the overflow flag, and loads
    // the output register, which is reloaded in the same cycle it is taken, so
    // results stream at one per cycle while they are taken and entries wait.

    logic            r_count_only;
    logic [15:0]     r_capacity;
    logic            w_cfg_write;
    logic            w_in_accept;
    logic            w_full;
    logic            w_head_valid;
    logic            w_pop;
    upd_pkg::t_entry w_entry;
    upd_pkg::t_entry w_head;

    // Registers are written on the access phase of a write transaction.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_only <= 1'b0;
            r_capacity   <= upd_pkg::CAP_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                upd_pkg::REG_COUNT_ONLY: r_count_only <= pwdata[0];
                upd_pkg::REG_CAPACITY:   r_capacity   <= pwdata[15:0];
                default:                 r_count_only <= r_count_only;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            upd_pkg::REG_COUNT_ONLY: prdata = {31'd0, r_count_only};
            upd_pkg::REG_CAPACITY:   prdata = {16'd0, r_capacity};
            default:                 prdata = 32'd0;
        endcase
    end

    // Input handshake depends only on queue occupancy.
    assign o_ready     = !w_full;
    assign w_in_accept = i_valid && o_ready;

    upd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_entry   (w_entry)
    );

    upd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_in_accept),
        .i_entry      (w_entry),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    upd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_count_only   (r_count_only),
        .i_capacity     (r_capacity),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_out_last     (o_out_last),
        .o_total_length (o_total_length),
        .o_overflow     (o_overflow)
    );

endmodule

// ===== design/upd_front.sv =====
// Front end: accepts raw bytes, tracks a pending '%' escape and releases decoded bytes.
// Depends on upd_pkg for the entry type and the hex helpers.
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    output upd_pkg::t_entry o_entry
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PCT   = 3'b010,
        ST_DIGIT = 3'b100
    } t_stage;

    t_stage     r_stage, n_stage;
    logic [7:0] r_digit, n_digit;
    logic       w_hex;
    logic       w_pct;

    always_comb begin
        w_hex         = upd_pkg::is_hex(i_in_byte);
        w_pct         = (i_in_byte == upd_pkg::PCT);
        o_entry.data  = '0;
        o_entry.count = 2'd0;
        o_entry.last  = i_in_last;
        n_stage       = ST_IDLE;
        n_digit       = r_digit;

        case (r_stage)
            ST_IDLE: begin
                if (w_pct) begin
                    n_stage = ST_PCT;
                end else begin
                    o_entry.data[0] = i_in_byte;
                    o_entry.count   = 2'd1;
                end
            end
            ST_PCT: begin
                if (w_hex) begin
                    n_stage = ST_DIGIT;
                    n_digit = i_in_byte;
                end else begin
                    // Broken escape: the '%' goes out literally, the byte starts over.
                    o_entry.data[0] = upd_pkg::PCT;
                    if (w_pct) begin
                        o_entry.count = 2'd1;
                        n_stage       = ST_PCT;
                    end else begin
                        o_entry.data[1] = i_in_byte;
                        o_entry.count   = 2'd2;
                    end
                end
            end
            ST_DIGIT: begin
                n_digit = 8'd0;
                if (w_hex) begin
                    o_entry.data[0] = {upd_pkg::hex_val(r_digit), upd_pkg::hex_val(i_in_byte)};
                    o_entry.count   = 2'd1;
                end else begin
                    o_entry.data[0] = upd_pkg::PCT;
                    o_entry.data[1] = r_digit;
                    if (w_pct) begin
                        o_entry.count = 2'd2;
                        n_stage       = ST_PCT;
                    end else begin
                        o_entry.data[2] = i_in_byte;
                        o_entry.count   = 2'd3;
                    end
                end
            end
            default: begin
                n_stage = ST_IDLE;
            end
        endcase

        // End of string: whatever escape is still held is flushed literally.
        if (i_in_last) begin
            if (n_stage == ST_PCT) begin
                case (o_entry.count)
                    2'd0:    o_entry.data[0] = upd_pkg::PCT;
                    2'd1:    o_entry.data[1] = upd_pkg::PCT;
                    default: o_entry.data[2] = upd_pkg::PCT;
                endcase
                o_entry.count = o_entry.count + 2'd1;
            end else if (n_stage == ST_DIGIT) begin
                o_entry.data[0] = upd_pkg::PCT;
                o_entry.data[1] = n_digit;
                o_entry.count   = 2'd2;
            end
            n_stage = ST_IDLE;
            n_digit = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
        end else if (i_accept) begin
            r_stage <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_digit <= n_digit;
        end
    end

endmodule

// ===== design/upd_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on upd_pkg for the entry type.
module upd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output upd_pkg::t_entry o_head
);

    upd_pkg::t_entry r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== design/upd_back.sv =====
// Back end: walks released bytes one per cycle unless stalled, counts length,
// applies capacity, drives the result register. Depends on upd_pkg's entry type.
module upd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_count_only,
    input  logic [15:0]     i_capacity,
    input  logic            i_head_valid,
    input  upd_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_out_last,
    output logic [15:0]     o_total_length,
    output logic            o_overflow
);

    logic [15:0] r_count;
    logic        r_ovf;
    logic [1:0]  r_pos;
    logic        r_out_valid;

    logic [7:0]  w_byte;
    logic        w_has, w_end, w_step, w_fits, w_take, w_emit;
    logic [15:0] w_cnt_inc, w_cnt_next;
    logic        w_ovf_next, w_final, w_final_ovf, w_load;

    always_comb begin
        case (r_pos)
            2'd0:    w_byte = i_head.data[0];
            2'd1:    w_byte = i_head.data[1];
            default: w_byte = i_head.data[2];
        endcase
        w_has      = (r_pos < i_head.count);
        w_end      = (i_head.count == 2'd0) || (r_pos == (i_head.count - 2'd1));
        w_step     = i_head_valid && (!r_out_valid || i_ready);
        w_fits     = !r_ovf && (i_count_only || (r_count < i_capacity));
        w_take     = w_has && w_fits;
        w_emit     = w_take && !i_count_only;
        w_cnt_inc  = (r_count == upd_pkg::CNT_MAX) ? r_count : r_count + 16'd1;
        w_cnt_next = w_take ? w_cnt_inc : r_count;
        w_ovf_next = r_ovf || (w_has && !w_fits);
        // An emitted byte of the string's last entry closes the string when it is
        // its last byte, or when the byte behind it will not fit (that one flags overflow).
        if (w_emit) begin
            w_final     = i_head.last && (w_end || (w_cnt_next >= i_capacity));
            w_final_ovf = !w_end;
        end else begin
            w_final     = i_head.last && w_end;
            w_final_ovf = w_ovf_next;
        end
        w_load = w_step && (w_emit || w_final);
        o_pop  = w_step && (w_end || w_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= upd_pkg::CNT_RESET;
            r_ovf       <= 1'b0;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_count <= w_final ? upd_pkg::CNT_RESET : w_cnt_next;
                r_ovf   <= w_final ? 1'b0 : w_ovf_next;
                r_pos   <= o_pop ? 2'd0 : r_pos + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_byte     <= w_emit ? w_byte : 8'd0;
            o_has_byte     <= w_emit;
            o_out_last     <= w_final;
            o_total_length <= (w_final && !w_final_ovf) ? w_cnt_next : 16'd0;
            o_overflow     <= w_final && w_final_ovf;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== design/upd_checker.sv =====
// Port-level checks on the decoder's result stream, bound to the top level.
// Depends only on the ports of uri_percent_decoder_core.
module upd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_has_byte,
    input logic        o_out_last,
    input logic [15:0] o_total_length,
    input logic        o_overflow
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_has_byte) &&
        $stable(o_out_last) && $stable(o_total_length) && $stable(o_overflow))
        else $error("result changed while stalled");

    // A result without a byte only exists to carry the end of a string.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_out_last && o_out_byte == 8'd0)
        else $error("empty result that is not final");

    // Length and overflow are reported on the final result only.
    a_mid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |-> o_total_length == 16'd0 && !o_overflow)
        else $error("length or overflow on a non-final result");

    // Overflow reports length zero; otherwise the terminator makes it at least one.
    a_len_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> (o_overflow == (o_total_length == 16'd0)))
        else $error("final length disagrees with overflow flag");

endmodule

bind uri_percent_decoder_core upd_checker u_upd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_byte     (o_out_byte),
    .o_has_byte     (o_has_byte),
    .o_out_last     (o_out_last),
    .o_total_length (o_total_length),
    .o_overflow     (o_overflow)
);
